// ===== design/bucketed_hash_dedup_set_top_defines.svh =====
// Assertion macros shared by the dedup set RTL.
`ifndef BUCKETED_HASH_DEDUP_SET_TOP_DEFINES_SVH
`define BUCKETED_HASH_DEDUP_SET_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define HDSET_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("hdset assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define HDSET_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hdset assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HDSET_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hdset assertion failed");

`else

`define HDSET_ASSERT_ALWAYS(lbl, cond)
`define HDSET_ASSERT_IMPLIES(lbl, ante, cons)
`define HDSET_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/hdset_pkg.sv =====
// Shared types and constants for the bucketed hash dedup set.
package hdset_pkg;

    localparam int KEY_W     = 64;
    localparam int BUCKETS   = 256;
    localparam int BUCKET_W  = 8;
    localparam int COUNT_W   = 12;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 16;

    // Result of one request, as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               bucket_full;
        logic               inserted;
        logic               present;
    } hdset_res_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } hdset_state_t;

endpackage

// ===== design/hdset_key_mem.sv =====
// Key store: one write port and one registered read port.
module hdset_key_mem
    import hdset_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/hdset_fill_tbl.sv =====
// Per-bucket fill counts in a memory, with a valid bit per bucket cleared at reset.
module hdset_fill_tbl
    import hdset_pkg::*;
#(
    parameter int FILL_W = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [BUCKET_W-1:0] rd_addr,
    output logic [FILL_W-1:0]   rd_data,
    input  logic                wr_en,
    input  logic [BUCKET_W-1:0] wr_addr,
    input  logic [FILL_W-1:0]   wr_data
);

    logic [FILL_W-1:0]  mem [BUCKETS];
    logic [BUCKETS-1:0] vld_reg;
    logic [FILL_W-1:0]  rd_data_reg;
    logic               rd_vld_reg;

    // Count storage.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: a bucket never written reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== design/hdset_ctrl.sv =====
// Request sequencer: fill lookup, way-by-way key compare, update and result.
`include "bucketed_hash_dedup_set_top_defines.svh"

module hdset_ctrl
    import hdset_pkg::*;
#(
    parameter int WAYS   = 8,
    parameter int FILL_W = 4,
    parameter int ADDR_W = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Request side.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [KEY_W-1:0]    s_key,
    // Fill table.
    output logic                fill_rd_en,
    output logic [BUCKET_W-1:0] fill_rd_addr,
    input  logic [FILL_W-1:0]   fill_rd_data,
    output logic                fill_wr_en,
    output logic [BUCKET_W-1:0] fill_wr_addr,
    output logic [FILL_W-1:0]   fill_wr_data,
    // Key store.
    output logic                key_rd_en,
    output logic [ADDR_W-1:0]   key_rd_addr,
    input  logic [KEY_W-1:0]    key_rd_data,
    output logic                key_wr_en,
    output logic [ADDR_W-1:0]   key_wr_addr,
    output logic [KEY_W-1:0]    key_wr_data,
    // Result side.
    input  logic                out_free,
    output logic                res_load,
    output hdset_res_t          res
);

    hdset_state_t        state_reg, state_next;
    logic                add_reg, add_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   rd_way_reg, rd_way_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                found_reg, found_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    logic [BUCKET_W-1:0] bucket;
    logic [ADDR_W-1:0]   bucket_base;
    logic                hit;
    logic                has_room;
    logic                do_insert;

    assign bucket      = key_reg[KEY_W-1 -: BUCKET_W];
    assign bucket_base = ADDR_W'(bucket) * ADDR_W'(WAYS);

    // Shared comparator, fed one stored way per cycle.
    assign hit = cmp_vld_reg && (key_rd_data == key_reg);

    assign has_room  = fill_reg < FILL_W'(WAYS);
    assign do_insert = add_reg && !found_reg && has_room;

    assign s_ready      = (state_reg == S_IDLE);
    assign fill_rd_en   = s_valid && s_ready;
    assign fill_rd_addr = s_key[KEY_W-1 -: BUCKET_W];

    assign fill_wr_addr = bucket;
    assign fill_wr_data = fill_reg + FILL_W'(1);
    assign key_rd_addr  = bucket_base + ADDR_W'(rd_way_reg);
    assign key_wr_addr  = bucket_base + ADDR_W'(fill_reg);
    assign key_wr_data  = key_reg;

    // Next-state and datapath control.
    always_comb begin
        state_next   = state_reg;
        add_next     = add_reg;
        key_next     = key_reg;
        fill_next    = fill_reg;
        rd_way_next  = rd_way_reg;
        cmp_vld_next = cmp_vld_reg;
        found_next   = found_reg;
        cnt_next     = cnt_reg;
        key_rd_en    = 1'b0;
        key_wr_en    = 1'b0;
        fill_wr_en   = 1'b0;
        res_load     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    add_next   = s_req_type;
                    key_next   = s_key;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                fill_next    = fill_rd_data;
                rd_way_next  = '0;
                cmp_vld_next = 1'b0;
                found_next   = 1'b0;
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                if (hit) begin
                    found_next   = 1'b1;
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                end else if (rd_way_reg < fill_reg) begin
                    key_rd_en    = 1'b1;
                    rd_way_next  = rd_way_reg + FILL_W'(1);
                    cmp_vld_next = 1'b1;
                end else begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    key_wr_en  = do_insert;
                    fill_wr_en = do_insert;
                    if (do_insert) begin
                        cnt_next = cnt_reg + COUNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result fields for the output stage.
    always_comb begin
        res.present     = found_reg;
        res.inserted    = do_insert;
        res.bucket_full = add_reg && !found_reg && !has_room;
        res.entry_count = cnt_next;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Request payload and scan registers.
    always_ff @(posedge aclk) begin
        add_reg    <= add_next;
        key_reg    <= key_next;
        fill_reg   <= fill_next;
        rd_way_reg <= rd_way_next;
        found_reg  <= found_next;
    end

    `HDSET_ASSERT_IMPLIES(a_rd_in_fill, key_rd_en, rd_way_reg < fill_reg)
    `HDSET_ASSERT_IMPLIES(a_fill_bound, state_reg == S_SCAN, fill_reg <= FILL_W'(WAYS))
    `HDSET_ASSERT_IMPLIES(a_res_excl, res_load, !(res.inserted && res.present) && !(res.inserted && res.bucket_full) && !(res.present && res.bucket_full))
    `HDSET_ASSERT_NEXT(a_cnt_hold, !(res_load && res.inserted), $stable(cnt_reg))
    `HDSET_ASSERT_IMPLIES(a_idle_no_mem, s_ready, !key_rd_en && !key_wr_en && !fill_wr_en)

endmodule

// ===== design/bucketed_hash_dedup_set_top.sv =====
// Top level of the bucketed hash dedup set: sequencer, stores and result register.
//
// Usage: each request on the s_ channel carries a 64-bit key in s_tdata and
// the request kind in s_tuser (0 = membership test, 1 = add if absent). The
// bucket is the key's top byte; each bucket holds up to WAYS keys.
// One result per request leaves on the m_ channel: present, inserted,
// bucket_full and the entry count after the request.
// Timing: the request is taken, then the bucket fill count is read, then
// the key store is scanned one stored way per cycle over its single read
// port, stopping early on a match, and a last step updates the stores and
// loads the result register. No new request is accepted until that last
// step is done; m_tvalid is driven from the result register.
// Reset empties the set: every bucket reads as empty and the count is zero.
// No clearing pass is needed. The result register holds a finished result
// while m_tready is low; the next request is still accepted and processed,
// and its sequencer waits in its last step until the register is free.
module bucketed_hash_dedup_set_top
    import hdset_pkg::*;
#(
    parameter int WAYS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [63:0] key
    input  logic                s_tuser,  // [0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [0] present, [1] inserted, [2] bucket_full,
                                          // [14:3] entry_count, [15] zero
);

    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int DEPTH  = BUCKETS * WAYS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                fill_rd_en;
    logic [BUCKET_W-1:0] fill_rd_addr;
    logic [FILL_W-1:0]   fill_rd_data;
    logic                fill_wr_en;
    logic [BUCKET_W-1:0] fill_wr_addr;
    logic [FILL_W-1:0]   fill_wr_data;
    logic                key_rd_en;
    logic [ADDR_W-1:0]   key_rd_addr;
    logic [KEY_W-1:0]    key_rd_data;
    logic                key_wr_en;
    logic [ADDR_W-1:0]   key_wr_addr;
    logic [KEY_W-1:0]    key_wr_data;
    logic                out_free;
    logic                res_load;
    hdset_res_t          res;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Sequencer with the shared key comparator.
    hdset_ctrl #(
        .WAYS   (WAYS),
        .FILL_W (FILL_W),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_req_type   (s_tuser),
        .s_key        (s_tdata),
        .fill_rd_en   (fill_rd_en),
        .fill_rd_addr (fill_rd_addr),
        .fill_rd_data (fill_rd_data),
        .fill_wr_en   (fill_wr_en),
        .fill_wr_addr (fill_wr_addr),
        .fill_wr_data (fill_wr_data),
        .key_rd_en    (key_rd_en),
        .key_rd_addr  (key_rd_addr),
        .key_rd_data  (key_rd_data),
        .key_wr_en    (key_wr_en),
        .key_wr_addr  (key_wr_addr),
        .key_wr_data  (key_wr_data),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

    // Per-bucket fill counts.
    hdset_fill_tbl #(
        .FILL_W (FILL_W)
    ) u_fill_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (fill_rd_en),
        .rd_addr (fill_rd_addr),
        .rd_data (fill_rd_data),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data)
    );

    // Stored keys, way w of bucket b at b * WAYS + w.
    hdset_key_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .aclk    (aclk),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data)
    );

    // Result register: free when empty or being taken this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_tdata_reg <= {1'b0, res.entry_count, res.bucket_full, res.inserted, res.present};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
